>>> hdl/wma_pkg.sv
// package for the windowed moving average block
// sizes, register indexes and sequencer states; no dependencies

package wma_pkg;

  localparam int DEPTH       = 1024;
  localparam int SAMPLE_BITS = 16;

  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int LEN_W   = $clog2(DEPTH + 1);
  localparam int SUM_W   = SAMPLE_BITS + ADDR_W + 1;
  localparam int MAG_W   = SUM_W - 1;
  localparam int DCNT_W  = $clog2(MAG_W);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE       = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV,
    ST_DONE
  } wma_state_e;

endpackage

>>> hdl/windowed_moving_average.sv
// windowed moving average top level
// uses wma_pkg and one wma_ram instance for the sample ring

// Each accepted sample is folded into a running sum kept beside a ring of the last N samples
// in a single ram, and one result is produced per sample: the sum divided by the samples held
// (or by N once full), truncated toward zero. When the window changes, a sample goes from
// acceptance to result through the accept with ring read, a read-modify-write state, the
// bit-serial restoring divider and the load of the output register; in stop mode with a full
// window no division runs and the last result is given again. The divider works one quotient
// bit per cycle over the 26-bit magnitude of the sum. One sample is in work at a time; a finished
// result waits in the output register while the next sample is taken. Configuration is always
// ready and should only be written while the block is idle.

module windowed_moving_average import wma_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [SAMPLE_BITS-1:0] average_o,
  output logic [LEN_W-1:0]              fill_count_o,
  output logic                          filling_o,
  output logic                          len_clamped_o
);

  wma_state_e state_q, state_d;

  logic [CFG_DATA_W-1:0]         window_len_q;
  logic                          mode_q;

  logic [ADDR_W-1:0]             wp_q;
  logic [LEN_W-1:0]              cnt_q;
  logic signed [SUM_W-1:0]       sum_q;
  logic [LEN_W-1:0]              alen_q;
  logic signed [SAMPLE_BITS-1:0] havg_q;

  logic signed [SAMPLE_BITS-1:0] s_q;
  logic                          filling_q;
  logic                          clamped_q;
  logic                          upd_q;

  logic [LEN_W-1:0]              div_q;
  logic [LEN_W-1:0]              rem_q;
  logic [MAG_W-1:0]              quo_q;
  logic                          neg_q;
  logic [DCNT_W-1:0]             dcnt_q;

  logic                          out_valid_q;

  logic                          in_accept;
  logic                          out_accept;
  logic [LEN_W-1:0]              n;
  logic                          clamped;
  logic                          empty;
  logic [ADDR_W-1:0]             e_wp;
  logic [LEN_W-1:0]              e_cnt;
  logic signed [SUM_W-1:0]       e_sum;
  logic signed [SAMPLE_BITS-1:0] e_havg;
  logic [LEN_W-1:0]              e_alen;
  logic [ADDR_W-1:0]             e_wp_w;
  logic                          full;

  logic                          ram_we;
  logic                          ram_re;
  logic [SAMPLE_BITS-1:0]        ram_rdata;

  logic signed [SUM_W-1:0]       s_ext;
  logic signed [SUM_W-1:0]       old_ext;
  logic signed [SUM_W-1:0]       new_sum;
  logic [SUM_W-1:0]              new_mag;
  logic [LEN_W-1:0]              wp_inc;

  logic [LEN_W:0]                rem_sh;
  logic                          ge;
  logic [LEN_W:0]                rem_sub;
  logic [MAG_W-1:0]              quo_neg;
  logic signed [SAMPLE_BITS-1:0] result;
  logic                          done_leave;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign done_leave = !out_valid_q || !out_stall_i;

  // clamp the configured length and decide whether the window empties
  always_comb begin
    clamped = 1'b0;
    n       = LEN_W'(window_len_q);
    if (window_len_q == '0) begin
      n       = LEN_W'(1);
      clamped = 1'b1;
    end else if (32'(window_len_q) > DEPTH) begin
      n       = LEN_W'(DEPTH);
      clamped = 1'b1;
    end
    empty  = ((n != alen_q) && !mode_q) || restart_i;
    e_wp   = empty ? '0 : wp_q;
    e_cnt  = empty ? '0 : cnt_q;
    e_sum  = empty ? '0 : sum_q;
    e_havg = empty ? '0 : havg_q;
    e_alen = empty ? n : alen_q;
    e_wp_w = (LEN_W'(e_wp) >= e_alen) ? '0 : e_wp;
    full   = e_cnt >= e_alen;
  end

  // sum update and divider setup
  always_comb begin
    s_ext   = SUM_W'(s_q);
    old_ext = SUM_W'($signed(ram_rdata));
    new_sum = filling_q ? (sum_q + s_ext) : (sum_q + s_ext - old_ext);
    new_mag = new_sum[SUM_W-1] ? SUM_W'(-new_sum) : SUM_W'(new_sum);
    wp_inc  = LEN_W'(wp_q) + LEN_W'(1);
  end

  // one restoring division step
  always_comb begin
    rem_sh  = {rem_q, quo_q[MAG_W-1]};
    ge      = rem_sh >= {1'b0, div_q};
    rem_sub = rem_sh - {1'b0, div_q};
    quo_neg = MAG_W'(-quo_q);
    result  = upd_q ? SAMPLE_BITS'(neg_q ? quo_neg : quo_q) : havg_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_RMW;
      end
      ST_RMW: begin
        state_d = upd_q ? ST_DIV : ST_DONE;
      end
      ST_DIV: begin
        if (dcnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (done_leave) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = 1'b1;
    ram_re     = 1'b0;
    ram_we     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        ram_re     = in_valid_i;
      end
      ST_RMW: begin
        ram_we = upd_q;
      end
      ST_DIV: begin
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  wma_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_q),
    .wdata_i(s_q),
    .re_i   (ram_re),
    .raddr_i(e_wp_w),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= CFG_DATA_W'(1);
      mode_q       <= 1'b0;
      wp_q         <= '0;
      cnt_q        <= '0;
      sum_q        <= '0;
      alen_q       <= LEN_W'(1);
      havg_q       <= '0;
      out_valid_q  <= 1'b0;
      dcnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == REG_WINDOW_LEN) window_len_q <= cfg_data_i;
        if (cfg_index_i == REG_MODE)       mode_q       <= cfg_data_i[0];
      end
      if (in_accept) begin
        wp_q   <= e_wp_w;
        cnt_q  <= e_cnt;
        sum_q  <= e_sum;
        havg_q <= e_havg;
        alen_q <= e_alen;
      end
      if (state_q == ST_RMW && upd_q) begin
        sum_q  <= new_sum;
        wp_q   <= (wp_inc >= alen_q) ? '0 : ADDR_W'(wp_inc);
        dcnt_q <= DCNT_W'(MAG_W - 1);
        if (filling_q) cnt_q <= cnt_q + LEN_W'(1);
      end
      if (state_q == ST_DIV) begin
        dcnt_q <= dcnt_q - DCNT_W'(1);
      end
      if (state_q == ST_DONE && done_leave) begin
        havg_q      <= result;
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload and divider datapath
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s_q       <= sample_i;
      filling_q <= !full;
      clamped_q <= clamped;
      upd_q     <= !full || !mode_q;
    end
    if (state_q == ST_RMW) begin
      div_q <= filling_q ? (cnt_q + LEN_W'(1)) : alen_q;
      rem_q <= '0;
      quo_q <= MAG_W'(new_mag);
      neg_q <= new_sum[SUM_W-1];
    end
    if (state_q == ST_DIV) begin
      rem_q <= ge ? LEN_W'(rem_sub) : LEN_W'(rem_sh);
      quo_q <= {quo_q[MAG_W-2:0], ge};
    end
    if (state_q == ST_DONE && done_leave) begin
      average_o     <= result;
      fill_count_o  <= cnt_q;
      filling_o     <= filling_q;
      len_clamped_o <= clamped_q;
    end
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

endmodule

>>> hdl/wma_ram.sv
// generic simple dual port ram with registered read
// one write port, one read port; no dependencies

module wma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for windowed_moving_average, with a queue-fed driver and a monitor
// that compares each result against a moving average predictor; depends on wma_pkg

module testbench;
  import wma_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] average;
    logic [LEN_W-1:0]              fill_count;
    logic                          filling;
    logic                          len_clamped;
  } avg_result_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          restart;
  } sample_item_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_valid_i = 1'b0;
  logic                          cfg_ready_o;
  logic [CFG_IDX_W-1:0]          cfg_index_i = REG_WINDOW_LEN;
  logic [CFG_DATA_W-1:0]         cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic signed [SAMPLE_BITS-1:0] sample_i = '0;
  logic                          restart_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] average_o;
  logic [LEN_W-1:0]              fill_count_o;
  logic                          filling_o;
  logic                          len_clamped_o;

  // predictor state and register shadows
  logic [CFG_DATA_W-1:0]         len_reg = 16'd1;
  logic                          mode_reg = 1'b0;
  logic signed [SAMPLE_BITS-1:0] ring_mem [DEPTH];
  int                            wr_ptr = 0;
  int                            held_cnt = 0;
  int                            win_len = 1;
  longint                        win_sum = 0;
  longint                        last_avg = 0;

  sample_item_t pending_q[$];
  avg_result_t  expected_q[$];
  avg_result_t  want_r;
  int           send_idle_pct = 0;
  int           recv_idle_pct = 0;
  logic         hold_input = 1'b0;
  int           err_cnt = 0;
  int           idle_cycles = 0;

  windowed_moving_average dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_i      (sample_i),
    .restart_i     (restart_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .average_o     (average_o),
    .fill_count_o  (fill_count_o),
    .filling_o     (filling_o),
    .len_clamped_o (len_clamped_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic avg_result_t predict_average(input logic signed [SAMPLE_BITS-1:0] smp,
                                                  input logic rst);
    int          n;
    avg_result_t r;
    n = int'(len_reg);
    r.len_clamped = (n == 0) || (n > DEPTH);
    if (n == 0) n = 1;
    else if (n > DEPTH) n = DEPTH;
    if ((n != win_len && !mode_reg) || rst) begin
      wr_ptr   = 0;
      held_cnt = 0;
      win_sum  = 0;
      last_avg = 0;
      win_len  = n;
    end
    if (wr_ptr >= win_len) wr_ptr = 0;
    r.filling = held_cnt < win_len;
    if (r.filling || !mode_reg) begin
      if (r.filling) begin
        win_sum += longint'(smp);
        held_cnt++;
      end else begin
        win_sum += longint'(smp) - longint'(ring_mem[wr_ptr]);
      end
      last_avg = win_sum / held_cnt;
      ring_mem[wr_ptr] = smp;
      wr_ptr = (wr_ptr + 1 >= win_len) ? 0 : wr_ptr + 1;
    end
    r.average    = SAMPLE_BITS'(last_avg);
    r.fill_count = LEN_W'(held_cnt);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input bit near_min);
    if (near_min) return SAMPLE_BITS'(-32768 + int'($urandom_range(7)));
    case ($urandom_range(9))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      2:       return '1;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic send(input logic signed [SAMPLE_BITS-1:0] v, input logic r);
    sample_item_t it;
    it.value   = v;
    it.restart = r;
    pending_q.push_back(it);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == REG_WINDOW_LEN) len_reg = data;
    else if (idx == REG_MODE) mode_reg = data[0];
    @(negedge clk_i);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] len_val,
                           input logic [CFG_DATA_W-1:0] mode_val);
    wait_drained();
    write_reg(REG_WINDOW_LEN, len_val);
    write_reg(REG_MODE, mode_val);
  endtask

  task automatic random_phase();
    int                    n_items;
    int                    eff;
    logic [CFG_DATA_W-1:0] len_val;
    logic [CFG_DATA_W-1:0] mode_val;
    case ($urandom_range(9))
      0:       len_val = '0;
      1:       len_val = CFG_DATA_W'($urandom_range(DEPTH + 1, 65535));
      2, 3:    len_val = CFG_DATA_W'($urandom_range(17, 64));
      default: len_val = CFG_DATA_W'($urandom_range(1, 16));
    endcase
    mode_val = CFG_DATA_W'($urandom);
    configure(len_val, mode_val);
    eff = (len_val == 0) ? 1 : (len_val > DEPTH) ? DEPTH : int'(len_val);
    n_items = $urandom_range(20, 50);
    // stop mode restarts about once per window so the hold is left again
    repeat (n_items)
      send(rand_sample(1'b0), $urandom_range(mode_val[0] ? eff + 1 : 40) == 0);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      sample_i   <= '0;
      restart_i  <= 1'b0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) begin
        expected_q.push_back(predict_average(sample_i, restart_i));
        void'(pending_q.pop_front());
      end
      if (pending_q.size() != 0 && !hold_input && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        sample_i   <= pending_q[0].value;
        restart_i  <= pending_q[0].restart;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected transaction: avg=%0d cnt=%0d filling=%0b clamped=%0b",
                   $time, average_o, fill_count_o, filling_o, len_clamped_o);
          err_cnt++;
        end else begin
          want_r = expected_q.pop_front();
          if (average_o !== want_r.average || fill_count_o !== want_r.fill_count ||
              filling_o !== want_r.filling || len_clamped_o !== want_r.len_clamped) begin
            $display("%0t: mismatch: expected avg=%0d cnt=%0d filling=%0b clamped=%0b",
                     $time, $signed(want_r.average), want_r.fill_count, want_r.filling,
                     want_r.len_clamped);
            $display("%0t:           actual   avg=%0d cnt=%0d filling=%0b clamped=%0b",
                     $time, average_o, fill_count_o, filling_o, len_clamped_o);
            err_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle_pct = 14;
    recv_idle_pct = 48;

    // reset values: one-sample window, continuous
    send(16'sh7FFF, 1'b0);
    send(16'sh8000, 1'b0);
    // zero length taken as one
    configure(16'd0, 16'd0);
    send(-1, 1'b0);
    send(1, 1'b0);
    // fill and slide with extreme values
    configure(16'd4, 16'd0);
    repeat (5) send(16'sh7FFF, 1'b0);
    repeat (5) send(16'sh8000, 1'b0);
    send(-7, 1'b1);
    send(2, 1'b0);
    // length above depth
    configure(16'd1025, 16'd0);
    send(-3, 1'b0);
    send(2, 1'b0);
    // stop mode, hold once full
    configure(16'd3, 16'd1);
    send(5, 1'b0);
    send(-6, 1'b0);
    send(7, 1'b0);
    send(100, 1'b0);
    // length change in stop mode waits for a restart
    configure(16'd2, 16'd1);
    send(9, 1'b0);
    send(4, 1'b1);
    send(8, 1'b0);
    send(12, 1'b0);
    // upper mode bits ignored
    configure(16'd2, 16'hFFFE);
    send(-5, 1'b0);
    send(-6, 1'b0);

    repeat (8) random_phase();

    wait_drained();
    send_idle_pct = 48;
    recv_idle_pct = 14;
    // full depth window near the negative limit, then sliding
    configure(16'hFFFF, 16'd0);
    for (int i = 0; i < 1100; i++) send(rand_sample(i < DEPTH + 4), 1'b0);
    while (pending_q.size() > 600) @(negedge clk_i);
    hold_input = 1'b1;
    while (in_valid_i || expected_q.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    hold_input = 1'b0;
    repeat (2) random_phase();

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (10) random_phase();

    wait_drained();
    repeat (40) @(negedge clk_i);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
